@@ hw/rtl/tilt_pkg.sv @@
// Shared types and constants for the tilt angle block.
// Holds the item structs, CORDIC widths and the micro-rotation angle table.
// No dependencies.
`default_nettype none

package tilt_pkg;

  // Input and result field widths
  localparam int ACCEL_W = 16;
  localparam int ANGLE_W = 17;

  // CORDIC sizing: operands are 17-bit after negation and are scaled by 2^16.
  localparam int OPD_W      = ACCEL_W + 1;
  localparam int FRAC_W     = 16;
  localparam int DP_W       = OPD_W + FRAC_W + 3;
  localparam int ACC_W      = 26;
  localparam int ATAN_LEN   = 24;
  localparam int CORDIC_STEPS = 16;
  localparam int STEPS      = (CORDIC_STEPS > ATAN_LEN) ? ATAN_LEN : CORDIC_STEPS;

  // Angle constants, accumulator in 2^-16 degree, result in 2^-8 degree
  localparam logic signed [ACC_W-1:0] QUARTER_TURN = 26'sd5898240;
  localparam logic signed [ACC_W-9:0] FULL_TURN    = 18'sd92160;
  localparam logic signed [ACC_W-1:0] ROUND_HALF   = 26'sd128;

  // atan(2^-i) in degrees times 2^16, rounded
  localparam logic signed [ACC_W-1:0] ATAN_TAB [ATAN_LEN] = '{
    26'sd2949120, 26'sd1740967, 26'sd919879, 26'sd466945,
    26'sd234379,  26'sd117305,  26'sd58666,  26'sd29335,
    26'sd14668,   26'sd7334,    26'sd3667,   26'sd1833,
    26'sd917,     26'sd458,     26'sd229,    26'sd115,
    26'sd57,      26'sd29,      26'sd14,     26'sd7,
    26'sd4,       26'sd2,       26'sd1,      26'sd0
  };

  typedef struct packed {
    logic signed [ACCEL_W-1:0] accel_x;
    logic signed [ACCEL_W-1:0] accel_y;
    logic signed [ACCEL_W-1:0] accel_z;
  } tilt_sample_t;

  typedef struct packed {
    logic [ANGLE_W-1:0] roll_deg;
    logic [ANGLE_W-1:0] pitch_deg;
  } tilt_angle_t;

  // What one lane hands to the merge stage
  typedef struct packed {
    logic                    zero;
    logic signed [ACC_W-1:0] acc;
  } tilt_lane_res_t;

  // Pipeline control toward the merge stage
  typedef struct packed {
    logic advance;
    logic last_valid;
  } tilt_ctl_t;

endpackage

`default_nettype wire

@@ hw/rtl/tilt_cordic_lane.sv @@
// One CORDIC vectoring lane: quadrant pre-rotation plus STEPS unrolled stages.
// Computes atan2(num, den) as an accumulator in 2^-16 degree.
// Depends on tilt_pkg.
`default_nettype none

module tilt_cordic_lane (
  input  logic                             clk,
  input  logic                             en,
  input  logic signed [tilt_pkg::OPD_W-1:0] num,
  input  logic signed [tilt_pkg::OPD_W-1:0] den,
  output tilt_pkg::tilt_lane_res_t         res
);
  import tilt_pkg::*;

  logic signed [DP_W-1:0]  x_q    [STEPS+1];
  logic signed [DP_W-1:0]  y_q    [STEPS+1];
  logic signed [ACC_W-1:0] acc_q  [STEPS+1];
  logic                    zero_q [STEPS+1];

  logic signed [OPD_W-1:0] px;
  logic signed [OPD_W-1:0] py;
  logic signed [ACC_W-1:0] acc0;

  // Turn a left half-plane vector by 90 degrees into the right half-plane
  always_comb begin
    px   = den;
    py   = num;
    acc0 = '0;
    if (den[OPD_W-1]) begin
      if (!num[OPD_W-1]) begin
        px   = num;
        py   = -den;
        acc0 = QUARTER_TURN;
      end else begin
        px   = -num;
        py   = den;
        acc0 = -QUARTER_TURN;
      end
    end
  end

  // Register the scaled, pre-rotated vector
  always_ff @(posedge clk) begin
    if (en) begin
      x_q[0]    <= {{(DP_W-OPD_W-FRAC_W){px[OPD_W-1]}}, px, {FRAC_W{1'b0}}};
      y_q[0]    <= {{(DP_W-OPD_W-FRAC_W){py[OPD_W-1]}}, py, {FRAC_W{1'b0}}};
      acc_q[0]  <= acc0;
      zero_q[0] <= (num == '0) && (den == '0);
    end
  end

  // One micro-rotation per stage, driven toward y = 0
  for (genvar i = 0; i < STEPS; i++) begin : g_iter
    logic signed [DP_W-1:0] xs;
    logic signed [DP_W-1:0] ys;

    assign xs = x_q[i] >>> i;
    assign ys = y_q[i] >>> i;

    always_ff @(posedge clk) begin
      if (en) begin
        zero_q[i+1] <= zero_q[i];
        if (!y_q[i][DP_W-1]) begin
          x_q[i+1]   <= x_q[i] + ys;
          y_q[i+1]   <= y_q[i] - xs;
          acc_q[i+1] <= acc_q[i] + ATAN_TAB[i];
        end else begin
          x_q[i+1]   <= x_q[i] - ys;
          y_q[i+1]   <= y_q[i] + xs;
          acc_q[i+1] <= acc_q[i] - ATAN_TAB[i];
        end
      end
    end
  end

  assign res.acc  = acc_q[STEPS];
  assign res.zero = zero_q[STEPS];

endmodule

`default_nettype wire

@@ hw/rtl/tilt_merge.sv @@
// Merge stage: rounds both lane accumulators to 1/256 degree, wraps into
// [0,360) and holds the result item in the output register. Depends on tilt_pkg.
`default_nettype none

module tilt_merge (
  input  logic                      clk,
  input  logic                      rst,
  input  tilt_pkg::tilt_ctl_t       ctl,
  input  tilt_pkg::tilt_lane_res_t  roll_res,
  input  tilt_pkg::tilt_lane_res_t  pitch_res,
  output logic                      angle_valid,
  output tilt_pkg::tilt_angle_t     angle
);
  import tilt_pkg::*;

  // Round half up, drop 8 bits, add a full turn to negative angles; a zero vector gives 0
  function automatic logic [ANGLE_W-1:0] round_wrap(input tilt_lane_res_t r);
    logic signed [ACC_W-1:0] rnd;
    logic signed [ACC_W-9:0] q;
    logic signed [ACC_W-9:0] w;
    rnd = r.acc + ROUND_HALF;
    q   = rnd[ACC_W-1:8];
    w   = q[ACC_W-9] ? (q + FULL_TURN) : q;
    if (r.zero) begin
      w = '0;
    end
    return w[ANGLE_W-1:0];
  endfunction

  // Output valid: load from the last stage whenever the pipe advances
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_valid <= 1'b0;
    end else if (ctl.advance) begin
      angle_valid <= ctl.last_valid;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    if (ctl.advance && ctl.last_valid) begin
      angle.roll_deg  <= round_wrap(roll_res);
      angle.pitch_deg <= round_wrap(pitch_res);
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/tilt_angle_from_accel.sv @@
// Tilt angles from one accelerometer item: roll = atan2(-x, z) and
// pitch = atan2(y, z), in 1/256 degree wrapped to [0,360), atan2(0,0) = 0.
// Two CORDIC lanes (roll, pitch) run side by side, each unrolled into
// STEPS stages (16) behind a pre-rotation register, followed by a merge
// stage that rounds, wraps and registers the result item. The block takes
// one item per cycle unless the output stalls; an item passes through the
// pre-rotation register, the STEPS stage registers and the merge register. When
// angle_ready is low with a result waiting, the whole pipe holds and
// sample_ready drops. There is no configuration and no state beyond the pipe.
// Depends on tilt_pkg, tilt_cordic_lane and tilt_merge.
`default_nettype none

module tilt_angle_from_accel (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   sample_valid,
  output logic                   sample_ready,
  input  tilt_pkg::tilt_sample_t sample,
  output logic                   angle_valid,
  input  logic                   angle_ready,
  output tilt_pkg::tilt_angle_t  angle
);
  import tilt_pkg::*;

  logic                    advance;
  logic [STEPS:0]          vld;
  logic signed [OPD_W-1:0] roll_num;
  logic signed [OPD_W-1:0] pitch_num;
  logic signed [OPD_W-1:0] den;
  tilt_lane_res_t          roll_res;
  tilt_lane_res_t          pitch_res;
  tilt_ctl_t               ctl;

  // Advance the pipe unless a result item is stuck at the output
  assign advance      = !angle_valid || angle_ready;
  assign sample_ready = advance;

  // Widen operands; roll uses -x, which stays exact at 17 bits
  assign roll_num  = {OPD_W{1'b0}} - {sample.accel_x[ACCEL_W-1], sample.accel_x};
  assign pitch_num = {sample.accel_y[ACCEL_W-1], sample.accel_y};
  assign den       = {sample.accel_z[ACCEL_W-1], sample.accel_z};

  // Track which stages hold an item
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (advance) begin
      vld <= {vld[STEPS-1:0], sample_valid};
    end
  end

  tilt_cordic_lane u_roll (
    .clk (clk),
    .en  (advance),
    .num (roll_num),
    .den (den),
    .res (roll_res)
  );

  tilt_cordic_lane u_pitch (
    .clk (clk),
    .en  (advance),
    .num (pitch_num),
    .den (den),
    .res (pitch_res)
  );

  assign ctl.advance    = advance;
  assign ctl.last_valid = vld[STEPS];

  tilt_merge u_merge (
    .clk         (clk),
    .rst         (rst),
    .ctl         (ctl),
    .roll_res    (roll_res),
    .pitch_res   (pitch_res),
    .angle_valid (angle_valid),
    .angle       (angle)
  );

  // An empty output register never blocks the input
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !angle_valid |-> sample_ready)
    else $error("sample_ready low with empty output register");

  // A stalled output freezes the stage occupancy
  a_pipe_holds: assert property (@(posedge clk) disable iff (rst)
    (angle_valid && !angle_ready) |=> $stable(vld))
    else $error("pipe moved while output stalled");

  // Result angles stay below a full turn
  a_angle_range: assert property (@(posedge clk) disable iff (rst)
    angle_valid |-> (angle.roll_deg < 17'd92160) && (angle.pitch_deg < 17'd92160))
    else $error("angle out of range");

endmodule

`default_nettype wire
